/* rtl/core/trer_pkg.sv */
package trer_pkg;

   localparam int COORD_BITS = 16;
   localparam int POINTS = 4;
   localparam int AXES = 3;
   localparam int IN_FIELD_BITS = POINTS * AXES * COORD_BITS;
   localparam int IN_DATA_W = ((IN_FIELD_BITS + 7) / 8) * 8;

   localparam int RATIO_BITS = 32;
   localparam int RATIO_FRAC_BITS_DEF = 16;

   // edge vectors and their products
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int LEN_W = PROD_W;
   localparam int CROSS_W = PROD_W;

   // determinant and circumcenter numerator vector
   localparam int DETP_W = DIFF_W + CROSS_W;
   localparam int DET_W = DETP_W + 1;
   localparam int NVP_W = LEN_W + CROSS_W + 1;
   localparam int NV_W = NVP_W + 1;

   // magnitudes split into limbs for the squaring stages
   localparam int DMAG_W = DET_W - 1;
   localparam int DH = (DMAG_W + 1) / 2;
   localparam int NMAG_W = NV_W - 1;
   localparam int NL = (NMAG_W + 2) / 3;
   localparam int DSQ_W = 2 * DMAG_W;
   localparam int NSQ_W = 2 * NMAG_W;
   localparam int NN_W = NSQ_W + 2;
   localparam int DL = (DSQ_W + 3) / 4;
   localparam int DM_W = DSQ_W + LEN_W;

   // long division and square root
   localparam int QUO_W = 2 * RATIO_BITS;
   localparam int REM_W = DM_W + 1;
   localparam int SR_W = RATIO_BITS + 3;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_REPEAT   = 2'd1,
      ST_FLAT     = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

endpackage

/* rtl/core/tetra_radius_edge_ratio_top.sv */
// Radius-edge ratio of a tetrahedron: one beat on req carries four vertices with signed
// Q8.8 coordinates; one beat on rsp returns circumradius divided by shortest edge as
// unsigned Q16.16 (truncated) plus a status code (ok, repeated point, flat tetrahedron,
// overflow); on any nonzero status the ratio is all ones. The pipeline takes one
// tetrahedron per cycle unless rsp stalls: 10 stages of vector math and wide squaring
// (no multiplier above about 35 x 35 bits per stage), one stage of overflow check, 64
// stages of restoring division (one quotient bit each), 33 stages of integer square
// root (a load stage, then one root bit each) and the output register. The whole pipeline
// holds while a result on rsp is not taken, so req_tready follows the output side.
module tetra_radius_edge_ratio_top #(
   parameter int RATIO_FRAC_BITS = trer_pkg::RATIO_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, p4_x, p4_y, p4_z
   input  logic [trer_pkg::IN_DATA_W-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // ratio
   output logic [trer_pkg::RATIO_BITS-1:0] rsp_tdata,
   // status
   output logic [1:0] rsp_tuser
);

   localparam int C = trer_pkg::COORD_BITS;
   localparam int DW = trer_pkg::DIFF_W;
   localparam int PW = trer_pkg::PROD_W;
   localparam int LW = trer_pkg::LEN_W;
   localparam int DETP_W = trer_pkg::DETP_W;
   localparam int DET_W = trer_pkg::DET_W;
   localparam int NVP_W = trer_pkg::NVP_W;
   localparam int NV_W = trer_pkg::NV_W;
   localparam int DMAG_W = trer_pkg::DMAG_W;
   localparam int DH = trer_pkg::DH;
   localparam int NMAG_W = trer_pkg::NMAG_W;
   localparam int NL = trer_pkg::NL;
   localparam int DSQ_W = trer_pkg::DSQ_W;
   localparam int NSQ_W = trer_pkg::NSQ_W;
   localparam int NN_W = trer_pkg::NN_W;
   localparam int DL = trer_pkg::DL;
   localparam int DM_W = trer_pkg::DM_W;
   localparam int QW = trer_pkg::QUO_W;
   localparam int REM_W = trer_pkg::REM_W;
   localparam int RB = trer_pkg::RATIO_BITS;
   localparam int SR_W = trer_pkg::SR_W;
   localparam int DIV_W = NN_W + 2 * RATIO_FRAC_BITS - 2;
   localparam int HI_W = DIV_W - QW;
   localparam int CMP_W = (HI_W > DM_W) ? HI_W : DM_W;

   // edge vectors: c1, c2, c3 from the first vertex, then e1, e2, e3 around the far face
   localparam int VA [6] = '{1, 2, 3, 2, 3, 1};
   localparam int VB [6] = '{0, 0, 0, 1, 2, 3};
   // cross products: c1 x c2, c3 x c1, c2 x c3
   localparam int CA [3] = '{0, 2, 1};
   localparam int CB [3] = '{1, 0, 2};
   localparam int N1 [3] = '{1, 2, 0};
   localparam int N2 [3] = '{2, 0, 1};

   logic pipe_en;
   assign pipe_en = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;

   logic signed [C-1:0] pt [0:3][0:2];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            pt[k][i] = req_tdata[(3*k+i)*C +: C];
         end
      end
   end

   // stage 1: edge vectors
   logic v1_ff;
   logic signed [DW-1:0] vec_ff [0:5][0:2];
   logic signed [DW-1:0] vec_in [0:5][0:2];
   always_comb begin
      for (int e = 0; e < 6; e++) begin
         for (int i = 0; i < 3; i++) begin
            vec_in[e][i] = DW'(pt[VA[e]][i]) - DW'(pt[VB[e]][i]);
         end
      end
   end

   // stage 2: squares and cross-product terms
   logic v2_ff;
   logic signed [PW-1:0] sq_ff [0:5][0:2];
   logic signed [PW-1:0] sq_in [0:5][0:2];
   logic signed [PW-1:0] xp_ff [0:2][0:2][0:1];
   logic signed [PW-1:0] xp_in [0:2][0:2][0:1];
   logic signed [DW-1:0] c1a_ff [0:2];
   always_comb begin
      for (int e = 0; e < 6; e++) begin
         for (int i = 0; i < 3; i++) begin
            sq_in[e][i] = vec_ff[e][i] * vec_ff[e][i];
         end
      end
      for (int x = 0; x < 3; x++) begin
         for (int i = 0; i < 3; i++) begin
            xp_in[x][i][0] = vec_ff[CA[x]][N1[i]] * vec_ff[CB[x]][N2[i]];
            xp_in[x][i][1] = vec_ff[CA[x]][N2[i]] * vec_ff[CB[x]][N1[i]];
         end
      end
   end

   // stage 3: squared lengths and cross products
   logic v3_ff;
   logic [LW-1:0] len_ff [0:5];
   logic [LW-1:0] len_in [0:5];
   logic signed [PW-1:0] cross_ff [0:2][0:2];
   logic signed [PW-1:0] cross_in [0:2][0:2];
   logic signed [DW-1:0] c1b_ff [0:2];
   always_comb begin
      for (int e = 0; e < 6; e++) begin
         len_in[e] = sq_ff[e][0] + sq_ff[e][1] + sq_ff[e][2];
      end
      for (int x = 0; x < 3; x++) begin
         for (int i = 0; i < 3; i++) begin
            cross_in[x][i] = xp_ff[x][i][0] - xp_ff[x][i][1];
         end
      end
   end

   // stage 4: first round of minimum, determinant and numerator products
   logic v4_ff;
   logic [LW-1:0] mina_ff [0:2];
   logic [LW-1:0] mina_in [0:2];
   logic signed [DETP_W-1:0] detp_ff [0:2];
   logic signed [DETP_W-1:0] detp_in [0:2];
   logic signed [NVP_W-1:0] nvp_ff [0:2][0:2];
   logic signed [NVP_W-1:0] nvp_in [0:2][0:2];
   always_comb begin
      for (int g = 0; g < 3; g++) begin
         mina_in[g] = (len_ff[2*g] < len_ff[2*g+1]) ? len_ff[2*g] : len_ff[2*g+1];
      end
      for (int i = 0; i < 3; i++) begin
         detp_in[i] = c1b_ff[i] * cross_ff[2][i];
         for (int j = 0; j < 3; j++) begin
            nvp_in[i][j] = $signed({1'b0, len_ff[2-j]}) * cross_ff[j][i];
         end
      end
   end

   // stage 5: shortest edge, determinant, numerator vector
   logic v5_ff;
   logic [LW-1:0] m5_ff;
   logic [LW-1:0] m5_in;
   logic signed [DET_W-1:0] det_ff;
   logic signed [DET_W-1:0] det_in;
   logic signed [NV_W-1:0] nv_ff [0:2];
   logic signed [NV_W-1:0] nv_in [0:2];
   logic [LW-1:0] min01;
   always_comb begin
      min01 = (mina_ff[0] < mina_ff[1]) ? mina_ff[0] : mina_ff[1];
      m5_in = (mina_ff[2] < min01) ? mina_ff[2] : min01;
      det_in = DET_W'(detp_ff[0]) + DET_W'(detp_ff[1]) + DET_W'(detp_ff[2]);
      for (int i = 0; i < 3; i++) begin
         nv_in[i] = NV_W'(nvp_ff[i][0]) + NV_W'(nvp_ff[i][1]) + NV_W'(nvp_ff[i][2]);
      end
   end

   // stage 6: degenerate cases and magnitudes
   logic v6_ff;
   trer_pkg::status_type st6_ff, st6_in;
   logic [LW-1:0] m6_ff;
   logic [2*DH-1:0] dmag_ff, dmag_in;
   logic [3*NL-1:0] nmag_ff [0:2];
   logic [3*NL-1:0] nmag_in [0:2];
   logic signed [DET_W-1:0] det_abs;
   logic signed [NV_W-1:0] nv_abs [0:2];
   always_comb begin
      if (m5_ff == '0) begin
         st6_in = trer_pkg::ST_REPEAT;
      end else if (det_ff == '0) begin
         st6_in = trer_pkg::ST_FLAT;
      end else begin
         st6_in = trer_pkg::ST_OK;
      end
      det_abs = det_ff[DET_W-1] ? -det_ff : det_ff;
      dmag_in = (2*DH)'(det_abs[DMAG_W-1:0]);
      for (int i = 0; i < 3; i++) begin
         nv_abs[i] = nv_ff[i][NV_W-1] ? -nv_ff[i] : nv_ff[i];
         nmag_in[i] = (3*NL)'(nv_abs[i][NMAG_W-1:0]);
      end
   end

   // stage 7: partial products of det^2 and |N|^2
   logic v7_ff;
   trer_pkg::status_type st7_ff;
   logic [LW-1:0] m7_ff;
   logic [2*DH-1:0] dpp_ff [0:2];
   logic [2*DH-1:0] dpp_in [0:2];
   logic [2*NL-1:0] npp_ff [0:2][0:5];
   logic [2*NL-1:0] npp_in [0:2][0:5];
   logic [DH-1:0] dlo, dhi;
   logic [NL-1:0] na0 [0:2];
   logic [NL-1:0] na1 [0:2];
   logic [NL-1:0] na2 [0:2];
   always_comb begin
      dlo = dmag_ff[DH-1:0];
      dhi = dmag_ff[2*DH-1:DH];
      dpp_in[0] = dlo * dlo;
      dpp_in[1] = dlo * dhi;
      dpp_in[2] = dhi * dhi;
      for (int i = 0; i < 3; i++) begin
         na0[i] = nmag_ff[i][NL-1:0];
         na1[i] = nmag_ff[i][2*NL-1:NL];
         na2[i] = nmag_ff[i][3*NL-1:2*NL];
         npp_in[i][0] = na0[i] * na0[i];
         npp_in[i][1] = na0[i] * na1[i];
         npp_in[i][2] = na0[i] * na2[i];
         npp_in[i][3] = na1[i] * na1[i];
         npp_in[i][4] = na1[i] * na2[i];
         npp_in[i][5] = na2[i] * na2[i];
      end
   end

   // stage 8: assemble det^2 and squared components of N
   logic v8_ff;
   trer_pkg::status_type st8_ff;
   logic [LW-1:0] m8_ff;
   logic [DSQ_W-1:0] dsq_ff, dsq_in;
   logic [NSQ_W-1:0] nsq_ff [0:2];
   logic [NSQ_W-1:0] nsq_in [0:2];
   logic [4*DH-1:0] dacc;
   logic [6*NL-1:0] nacc [0:2];
   always_comb begin
      dacc = ((4*DH)'(dpp_ff[2]) << (2*DH)) + ((4*DH)'(dpp_ff[1]) << (DH+1))
           + (4*DH)'(dpp_ff[0]);
      dsq_in = dacc[DSQ_W-1:0];
      for (int i = 0; i < 3; i++) begin
         nacc[i] = (6*NL)'(npp_ff[i][0])
                 + ((6*NL)'(npp_ff[i][1]) << (NL+1))
                 + ((6*NL)'(npp_ff[i][3]) << (2*NL))
                 + ((6*NL)'(npp_ff[i][2]) << (2*NL+1))
                 + ((6*NL)'(npp_ff[i][4]) << (3*NL+1))
                 + ((6*NL)'(npp_ff[i][5]) << (4*NL));
         nsq_in[i] = nacc[i][NSQ_W-1:0];
      end
   end

   // stage 9: |N|^2 and limb products of det^2 * m
   logic v9_ff;
   trer_pkg::status_type st9_ff;
   logic [NN_W-1:0] nn9_ff, nn9_in;
   logic [DL+LW-1:0] dmp_ff [0:3];
   logic [DL+LW-1:0] dmp_in [0:3];
   logic [4*DL-1:0] dsq_pad;
   always_comb begin
      nn9_in = NN_W'(nsq_ff[0]) + NN_W'(nsq_ff[1]) + NN_W'(nsq_ff[2]);
      dsq_pad = (4*DL)'(dsq_ff);
      for (int j = 0; j < 4; j++) begin
         dmp_in[j] = dsq_pad[j*DL +: DL] * m8_ff;
      end
   end

   // stage 10: det^2 * m
   logic v10_ff;
   trer_pkg::status_type st10_ff;
   logic [NN_W-1:0] nn10_ff;
   logic [DM_W-1:0] dm10_ff, dm10_in;
   logic [4*DL+LW-1:0] dmacc;
   always_comb begin
      dmacc = '0;
      for (int j = 0; j < 4; j++) begin
         dmacc = dmacc + ((4*DL+LW)'(dmp_ff[j]) << (j*DL));
      end
      dm10_in = dmacc[DM_W-1:0];
   end

   // long division: quotient of (|N|^2 << (2R-2)) by det^2 * m, one bit a stage
   logic dv_ff [0:QW];
   logic dv_in [0:QW];
   trer_pkg::status_type dst_ff [0:QW];
   trer_pkg::status_type dst_in [0:QW];
   logic [REM_W-1:0] drem_ff [0:QW];
   logic [REM_W-1:0] drem_in [0:QW];
   logic [QW-1:0] dquo_ff [0:QW];
   logic [QW-1:0] dquo_in [0:QW];
   logic [QW-1:0] dlow_ff [0:QW];
   logic [QW-1:0] dlow_in [0:QW];
   logic [DM_W-1:0] ddm_ff [0:QW];
   logic [DM_W-1:0] ddm_in [0:QW];
   logic [DIV_W-1:0] dvd;
   logic [HI_W-1:0] dvd_hi;
   logic [REM_W-1:0] dtrial [0:QW-1];
   logic dge [0:QW-1];
   always_comb begin
      dvd = DIV_W'(nn10_ff) << (2*RATIO_FRAC_BITS - 2);
      dvd_hi = dvd[DIV_W-1:QW];
      dv_in[0] = v10_ff;
      // quotient of 2^64 or more cannot be shown in Q16.16
      if (st10_ff == trer_pkg::ST_OK && CMP_W'(dvd_hi) >= CMP_W'(dm10_ff)) begin
         dst_in[0] = trer_pkg::ST_OVERFLOW;
      end else begin
         dst_in[0] = st10_ff;
      end
      drem_in[0] = REM_W'(dvd_hi);
      dquo_in[0] = '0;
      dlow_in[0] = dvd[QW-1:0];
      ddm_in[0] = dm10_ff;
      for (int k = 0; k < QW; k++) begin
         dtrial[k] = {drem_ff[k][REM_W-2:0], dlow_ff[k][QW-1]};
         dge[k] = dtrial[k] >= {1'b0, ddm_ff[k]};
         drem_in[k+1] = dge[k] ? dtrial[k] - {1'b0, ddm_ff[k]} : dtrial[k];
         dquo_in[k+1] = {dquo_ff[k][QW-2:0], dge[k]};
         dlow_in[k+1] = dlow_ff[k] << 1;
         ddm_in[k+1] = ddm_ff[k];
         dv_in[k+1] = dv_ff[k];
         dst_in[k+1] = dst_ff[k];
      end
   end

   // integer square root of the quotient, one root bit a stage
   logic sv_ff [0:RB];
   logic sv_in [0:RB];
   trer_pkg::status_type sst_ff [0:RB];
   trer_pkg::status_type sst_in [0:RB];
   logic [QW-1:0] sx_ff [0:RB];
   logic [QW-1:0] sx_in [0:RB];
   logic [SR_W-1:0] srem_ff [0:RB];
   logic [SR_W-1:0] srem_in [0:RB];
   logic [RB-1:0] sroot_ff [0:RB];
   logic [RB-1:0] sroot_in [0:RB];
   logic [SR_W-1:0] strem [0:RB-1];
   logic [SR_W-1:0] strial [0:RB-1];
   logic sge [0:RB-1];
   always_comb begin
      sv_in[0] = dv_ff[QW];
      sst_in[0] = dst_ff[QW];
      sx_in[0] = dquo_ff[QW];
      srem_in[0] = '0;
      sroot_in[0] = '0;
      for (int j = 0; j < RB; j++) begin
         strem[j] = {srem_ff[j][SR_W-3:0], sx_ff[j][QW-1:QW-2]};
         strial[j] = {1'b0, sroot_ff[j], 2'b01};
         sge[j] = strem[j] >= strial[j];
         srem_in[j+1] = sge[j] ? strem[j] - strial[j] : strem[j];
         sroot_in[j+1] = {sroot_ff[j][RB-2:0], sge[j]};
         sx_in[j+1] = sx_ff[j] << 2;
         sv_in[j+1] = sv_ff[j];
         sst_in[j+1] = sst_ff[j];
      end
   end

   // output register
   logic rsp_valid_ff;
   logic [RB-1:0] ratio_ff, ratio_in;
   trer_pkg::status_type status_ff;
   always_comb begin
      ratio_in = (sst_ff[RB] == trer_pkg::ST_OK) ? sroot_ff[RB] : '1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
         v10_ff <= 1'b0;
         dv_ff <= '{default: 1'b0};
         sv_ff <= '{default: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
         v10_ff <= v9_ff;
         dv_ff <= dv_in;
         sv_ff <= sv_in;
         rsp_valid_ff <= sv_ff[RB];
      end
   end

   // payload: hold while the output side stalls
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         vec_ff <= vec_in;
         sq_ff <= sq_in;
         xp_ff <= xp_in;
         c1a_ff <= vec_ff[0];
         len_ff <= len_in;
         cross_ff <= cross_in;
         c1b_ff <= c1a_ff;
         mina_ff <= mina_in;
         detp_ff <= detp_in;
         nvp_ff <= nvp_in;
         m5_ff <= m5_in;
         det_ff <= det_in;
         nv_ff <= nv_in;
         st6_ff <= st6_in;
         m6_ff <= m5_ff;
         dmag_ff <= dmag_in;
         nmag_ff <= nmag_in;
         st7_ff <= st6_ff;
         m7_ff <= m6_ff;
         dpp_ff <= dpp_in;
         npp_ff <= npp_in;
         st8_ff <= st7_ff;
         m8_ff <= m7_ff;
         dsq_ff <= dsq_in;
         nsq_ff <= nsq_in;
         st9_ff <= st8_ff;
         nn9_ff <= nn9_in;
         dmp_ff <= dmp_in;
         st10_ff <= st9_ff;
         nn10_ff <= nn9_ff;
         dm10_ff <= dm10_in;
         dst_ff <= dst_in;
         drem_ff <= drem_in;
         dquo_ff <= dquo_in;
         dlow_ff <= dlow_in;
         ddm_ff <= ddm_in;
         sst_ff <= sst_in;
         sx_ff <= sx_in;
         srem_ff <= srem_in;
         sroot_ff <= sroot_in;
         ratio_ff <= ratio_in;
         status_ff <= sst_ff[RB];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = ratio_ff;
   assign rsp_tuser = status_ff;

   a_saturate: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != trer_pkg::ST_OK) |-> rsp_tdata == '1)
      else $error("nonzero status without saturated ratio");

   a_repeat_zero_edge: assert property (@(posedge clock) disable iff (reset)
      (v6_ff && st6_ff == trer_pkg::ST_REPEAT) |-> m6_ff == '0)
      else $error("repeated point flagged with nonzero shortest edge");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(dv_ff[QW]) && $stable(sv_ff[0]))
      else $error("pipeline advanced during stall");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output register");

endmodule

/* bench/tetra_radius_edge_ratio_top_tb.sv */
`timescale 1ns / 100ps

module tetra_radius_edge_ratio_top_tb;

   localparam int RFRAC = trer_pkg::RATIO_FRAC_BITS_DEF;
   localparam int LATENCY = 109;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 640;
   localparam int QUIET_ITEMS = 100;

   typedef logic signed [255:0] big_type;
   typedef big_type vec_type[3];

   typedef struct packed {
      logic [trer_pkg::RATIO_BITS-1:0] ratio;
      trer_pkg::status_type            status;
   } quality_type;

   typedef struct {
      logic [trer_pkg::IN_DATA_W-1:0] tet;
      bit                             typed;
      quality_type                    want;
   } tet_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [trer_pkg::IN_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [trer_pkg::RATIO_BITS-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   quality_type pending_q[$];
   tet_row_type rows[$];
   int failures = 0;
   int cycles = 0;
   bit quiet = 1'b0;
   int stall_left = 0;

   tetra_radius_edge_ratio_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic logic [trer_pkg::IN_DATA_W-1:0] tet_pack(input int c[12]);
      logic [trer_pkg::IN_DATA_W-1:0] d;
      d = '0;
      for (int i = 0; i < 12; i++) d[16*i +: 16] = c[i][15:0];
      return d;
   endfunction

   function automatic vec_type vsub(input vec_type a, input vec_type b);
      vec_type r;
      for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
      return r;
   endfunction

   function automatic big_type vdot(input vec_type a, input vec_type b);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
   endfunction

   function automatic vec_type vcross(input vec_type a, input vec_type b);
      vec_type r;
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
      return r;
   endfunction

   // exact radius-edge ratio, truncated to Q16.16
   function automatic quality_type edge_ratio(input logic [trer_pkg::IN_DATA_W-1:0] d);
      vec_type p[4];
      vec_type c1, c2, c3, x12, x31, x23;
      vec_type nv;
      big_type l1, l2, l3, m, sq, det, num, den, q, t;
      quality_type r;
      for (int k = 0; k < 4; k++)
         for (int i = 0; i < 3; i++) p[k][i] = $signed(d[16*(3*k+i) +: 16]);
      r.ratio = '1;
      m = vdot(vsub(p[0], p[1]), vsub(p[0], p[1]));
      for (int a = 0; a < 4; a++)
         for (int b = a + 1; b < 4; b++) begin
            sq = vdot(vsub(p[a], p[b]), vsub(p[a], p[b]));
            if (sq < m) m = sq;
         end
      if (m == 0) begin
         r.status = trer_pkg::ST_REPEAT;
         return r;
      end
      c1 = vsub(p[1], p[0]);
      c2 = vsub(p[2], p[0]);
      c3 = vsub(p[3], p[0]);
      x12 = vcross(c1, c2);
      x31 = vcross(c3, c1);
      x23 = vcross(c2, c3);
      det = vdot(c1, x23);
      if (det == 0) begin
         r.status = trer_pkg::ST_FLAT;
         return r;
      end
      l1 = vdot(c1, c1);
      l2 = vdot(c2, c2);
      l3 = vdot(c3, c3);
      for (int i = 0; i < 3; i++) nv[i] = x12[i] * l3 + x31[i] * l2 + x23[i] * l1;
      num = vdot(nv, nv) <<< (2 * RFRAC);
      den = det * det * m * 4;
      if ((den <<< 64) <= num) begin
         r.status = trer_pkg::ST_OVERFLOW;
         return r;
      end
      q = 0;
      for (int b = 31; b >= 0; b--) begin
         t = q | (big_type'(1) <<< b);
         if (t * t * den <= num) q = t;
      end
      r.ratio = q[31:0];
      r.status = trer_pkg::ST_OK;
      return r;
   endfunction

   task automatic send_tet(input logic [trer_pkg::IN_DATA_W-1:0] d, input bit typed,
                           input quality_type want);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      pending_q.push_back(typed ? want : edge_ratio(d));
   endtask

   // random receiver stalls in bursts
   always @(negedge clock) begin
      if (stall_left > 0 && !quiet) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!reset && !quiet && $urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      quality_type exp_q;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            $error("unexpected beat: ratio %h status %0d", rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            exp_q = pending_q.pop_front();
            if (rsp_tdata !== exp_q.ratio) begin
               $error("ratio: expected %h actual %h", exp_q.ratio, rsp_tdata);
               failures++;
            end
            if (rsp_tuser !== exp_q.status) begin
               $error("status: expected %0d actual %0d", exp_q.status, rsp_tuser);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic add_row(input int c[12], input bit typed,
                          input trer_pkg::status_type st);
      tet_row_type r;
      r.tet = tet_pack(c);
      r.typed = typed;
      r.want.ratio = '1;
      r.want.status = st;
      rows.push_back(r);
   endtask

   function automatic int rcoord(input int span);
      if (span >= 32768) return $signed(16'($urandom));
      return $urandom_range(0, 2 * span) - span;
   endfunction

   initial begin
      int c[12];
      int span, kind, a, b;
      quality_type none;
      none = '0;

      // repeated points, flat, overflow-prone slivers, extremes
      add_row('{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1, trer_pkg::ST_REPEAT);
      add_row('{5,6,7, 5,6,7, 256,0,0, 0,0,256}, 1, trer_pkg::ST_REPEAT);
      add_row('{0,0,0, 256,0,0, 0,256,0, 256,0,0}, 1, trer_pkg::ST_REPEAT);
      add_row('{-32768,-32768,-32768, -32768,-32768,-32768, 32767,32767,32767, 0,0,0},
              1, trer_pkg::ST_REPEAT);
      add_row('{0,0,0, 256,0,0, 0,256,0, 256,256,0}, 1, trer_pkg::ST_FLAT);
      add_row('{0,0,0, 1,1,1, 2,2,2, 3,3,3}, 1, trer_pkg::ST_FLAT);
      add_row('{-32768,0,0, 32767,0,0, 0,-32768,0, 0,32767,0}, 1, trer_pkg::ST_FLAT);
      add_row('{0,0,0, 256,0,0, 0,256,0, 0,0,256}, 0, trer_pkg::ST_OK);
      add_row('{0,0,0, 1,0,0, 0,1,0, 0,0,1}, 0, trer_pkg::ST_OK);
      add_row('{-32768,-32768,-32768, 32767,-32768,-32768, -32768,32767,-32768,
                -32768,-32768,32767}, 0, trer_pkg::ST_OK);
      add_row('{32767,32767,32767, -32768,32767,32767, 32767,-32768,32767,
                32767,32767,-32768}, 0, trer_pkg::ST_OK);
      add_row('{0,0,0, 32767,0,0, 0,32767,0, -32768,-32768,1}, 0, trer_pkg::ST_OK);
      add_row('{0,0,0, 1,0,0, 0,1,0, 32767,32767,1}, 0, trer_pkg::ST_OK);
      add_row('{0,0,0, 32767,0,0, 0,32767,0, 100,100,1}, 0, trer_pkg::ST_OK);
      add_row('{-1,-1,-1, 1,-1,-1, -1,1,-1, -1,-1,1}, 0, trer_pkg::ST_OK);
      add_row('{100,200,300, -400,500,-600, 700,-800,900, -1000,1100,1200}, 0,
              trer_pkg::ST_OK);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_tet(rows[i].tet, rows[i].typed, rows[i].want);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         // hold until the pipeline has drained once
         if (n == RANDOM_ITEMS / 2) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (pending_q.size() != 0) @(posedge clock);
         end
         kind = $urandom_range(0, 9);
         span = (kind < 4) ? 32768 : (kind < 7) ? 300 : 4;
         for (int i = 0; i < 12; i++) c[i] = rcoord(span);
         if (kind == 7) begin
            // repeat one vertex over another
            a = $urandom_range(0, 3);
            b = (a + $urandom_range(1, 3)) % 4;
            for (int i = 0; i < 3; i++) c[3*b+i] = c[3*a+i];
         end else if (kind == 8) begin
            // fourth vertex completes a parallelogram: coplanar
            for (int i = 0; i < 12; i++) c[i] = rcoord(1000);
            for (int i = 0; i < 3; i++) c[9+i] = c[3+i] + c[6+i] - c[i];
         end
         send_tet(tet_pack(c), 0, none);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (pending_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* tetra_radius_edge_ratio_top.f */
rtl/core/trer_pkg.sv
rtl/core/tetra_radius_edge_ratio_top.sv
bench/tetra_radius_edge_ratio_top_tb.sv
